### design/marching_squares_circle_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// marching squares circle classifier assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef MARCHING_SQUARES_CIRCLE_CLASSIFIER_UNIT_ASSERT_SVH
`define MARCHING_SQUARES_CIRCLE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define MSCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mscc assertion failed");

// next-cycle implication
`define MSCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mscc assertion failed");

`endif

### design/mscc_pkg.sv
// ----------------------------------------------------------------------------
// mscc_pkg
// types and constants shared by the circle classifier modules
// ----------------------------------------------------------------------------
package mscc_pkg;

   localparam int MAX_CIRCLES = 16;
   localparam int COORD_BITS  = 16;
   localparam int NUM_CORNERS = 4;
   localparam int COUNT_BITS  = 5;
   localparam int IDX_BITS    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
   localparam int CNT_BITS    = $clog2(MAX_CIRCLES + 1);
   localparam int SQ_BITS     = 2 * COORD_BITS;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef point_type [NUM_CORNERS-1:0] corner_set_type;

   typedef struct packed {
      coord_type cx;
      coord_type cy;
      coord_type r;
   } circle_type;

   // corner k reports on bit NUM_CORNERS-1-k
   typedef struct packed {
      logic                   busy;
      logic                   valid;
      logic [NUM_CORNERS-1:0] hits;
   } hit_type;

endpackage

### design/mscc_circle_mem.sv
// ----------------------------------------------------------------------------
// mscc_circle_mem
// circle table, one write port and one registered read port
// ----------------------------------------------------------------------------
module mscc_circle_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [mscc_pkg::IDX_BITS-1:0] wr_addr,
   input  mscc_pkg::circle_type          wr_data,
   input  logic [mscc_pkg::IDX_BITS-1:0] rd_addr,
   output mscc_pkg::circle_type          rd_data
);
   import mscc_pkg::*;

   circle_type mem_ff [MAX_CIRCLES];
   circle_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mscc_dist_unit.sv
// ----------------------------------------------------------------------------
// mscc_dist_unit
// pipelined distance test of one circle against all four corners
// ----------------------------------------------------------------------------
module mscc_dist_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  mscc_pkg::circle_type     circle,
   input  mscc_pkg::corner_set_type corners,
   output mscc_pkg::hit_type        hit
);
   import mscc_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s2_valid_ff, s2_valid_in;
   coord_type             dx_ff [NUM_CORNERS];
   coord_type             dx_in [NUM_CORNERS];
   coord_type             dy_ff [NUM_CORNERS];
   coord_type             dy_in [NUM_CORNERS];
   coord_type             r_ff, r_in;
   logic [SQ_BITS-1:0]    sqx_ff [NUM_CORNERS];
   logic [SQ_BITS-1:0]    sqx_in [NUM_CORNERS];
   logic [SQ_BITS-1:0]    sqy_ff [NUM_CORNERS];
   logic [SQ_BITS-1:0]    sqy_in [NUM_CORNERS];
   logic [SQ_BITS-1:0]    r2_ff, r2_in;
   logic [SQ_BITS:0]      dist2 [NUM_CORNERS];
   logic [NUM_CORNERS-1:0] hits;

   // stage 1: absolute differences
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         dx_in[k] = (corners[k].x >= circle.cx) ? corners[k].x - circle.cx
                                                 : circle.cx - corners[k].x;
         dy_in[k] = (corners[k].y >= circle.cy) ? corners[k].y - circle.cy
                                                 : circle.cy - corners[k].y;
      end
      r_in        = circle.r;
      s1_valid_in = in_valid;
   end

   // stage 2: squares
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         sqx_in[k] = SQ_BITS'(dx_ff[k]) * SQ_BITS'(dx_ff[k]);
         sqy_in[k] = SQ_BITS'(dy_ff[k]) * SQ_BITS'(dy_ff[k]);
      end
      r2_in       = SQ_BITS'(r_ff) * SQ_BITS'(r_ff);
      s2_valid_in = s1_valid_ff;
   end

   // stage 3: sum and compare
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         dist2[k] = {1'b0, sqx_ff[k]} + {1'b0, sqy_ff[k]};
         hits[NUM_CORNERS-1-k] = (dist2[k] <= {1'b0, r2_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      r_ff   <= r_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      r2_ff  <= r2_in;
   end

   assign hit.busy  = s1_valid_ff | s2_valid_ff;
   assign hit.valid = s2_valid_ff;
   assign hit.hits  = hits;

endmodule

### design/marching_squares_circle_classifier_unit.sv
// ----------------------------------------------------------------------------
// marching_squares_circle_classifier_unit
// marching-squares case of one tile against a table of circles
// ----------------------------------------------------------------------------
// A load request (req_command 0) writes one circle entry and gives no result;
// busy stays low. A classify request scans the first circle_count table
// entries, at most MAX_CIRCLES of them, one circle per cycle through the
// shared distance pipeline that tests all four corners at once, and busy is
// high until the result strobe. rsp_case_code is valid only in the single
// cycle that rsp_strobe is high and must be taken there: the unit cannot be
// stalled. Reading a table entry that was never loaded gives an undefined
// case.
module marching_squares_circle_classifier_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_command,
   input  logic [3:0]                      req_slot,
   input  logic [15:0]                     req_radius,
   input  logic [15:0]                     req_point0_x,
   input  logic [15:0]                     req_point0_y,
   input  logic [15:0]                     req_point1_x,
   input  logic [15:0]                     req_point1_y,
   input  logic [15:0]                     req_point2_x,
   input  logic [15:0]                     req_point2_y,
   input  logic [15:0]                     req_point3_x,
   input  logic [15:0]                     req_point3_y,
   output logic                            rsp_strobe,
   output logic [3:0]                      rsp_case_code,
   input  logic                            csr_write_enable,
   input  logic [mscc_pkg::COUNT_BITS-1:0] csr_write_data
);
   import mscc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_type;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    limit_ff, limit_in;
   logic [CNT_BITS-1:0]    count_clamped;
   logic [COUNT_BITS-1:0]  csr_count_ff, csr_count_in;
   corner_set_type         corners_ff, corners_in;
   logic [NUM_CORNERS-1:0] code_ff, code_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]             rsp_case_code_ff, rsp_case_code_in;
   logic                   accept;
   logic                   mem_wr_en;
   circle_type             mem_wr_data;
   circle_type             mem_rd_data;
   hit_type                hit;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign mem_wr_en = accept && (req_command == CMD_LOAD)
                      && (32'(req_slot) < MAX_CIRCLES);
   assign mem_wr_data.cx = COORD_BITS'(req_point0_x);
   assign mem_wr_data.cy = COORD_BITS'(req_point0_y);
   assign mem_wr_data.r  = COORD_BITS'(req_radius);

   assign count_clamped = (32'(csr_count_ff) > MAX_CIRCLES) ? CNT_BITS'(MAX_CIRCLES)
                                                             : CNT_BITS'(csr_count_ff);

   mscc_circle_mem u_circle_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (IDX_BITS'(req_slot)),
      .wr_data (mem_wr_data),
      .rd_addr (idx_ff[IDX_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   mscc_dist_unit u_dist_unit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .circle   (mem_rd_data),
      .corners  (corners_ff),
      .hit      (hit)
   );

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      limit_in         = limit_ff;
      corners_in       = corners_ff;
      code_in          = code_ff;
      rsp_strobe_in    = 1'b0;
      rsp_case_code_in = rsp_case_code_ff;
      rd_valid_in      = (state_ff == ST_SCAN);
      csr_count_in     = csr_write_enable ? csr_write_data : csr_count_ff;

      if (hit.valid) begin
         code_in = code_ff | hit.hits;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_CLASSIFY)) begin
               corners_in[0].x = COORD_BITS'(req_point0_x);
               corners_in[0].y = COORD_BITS'(req_point0_y);
               corners_in[1].x = COORD_BITS'(req_point1_x);
               corners_in[1].y = COORD_BITS'(req_point1_y);
               corners_in[2].x = COORD_BITS'(req_point2_x);
               corners_in[2].y = COORD_BITS'(req_point2_y);
               corners_in[3].x = COORD_BITS'(req_point3_x);
               corners_in[3].y = COORD_BITS'(req_point3_y);
               code_in         = '0;
               idx_in          = '0;
               limit_in        = count_clamped;
               state_in        = (count_clamped == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (CNT_BITS'(idx_ff + 1'b1) == limit_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !hit.busy) begin
               state_in         = ST_IDLE;
               rsp_strobe_in    = 1'b1;
               rsp_case_code_in = 4'(code_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         csr_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         csr_count_ff  <= csr_count_in;
      end
      limit_ff         <= limit_in;
      corners_ff       <= corners_in;
      code_ff          <= code_in;
      rsp_case_code_ff <= rsp_case_code_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_case_code = rsp_case_code_ff;

endmodule

### design/mscc_checker.sv
// ----------------------------------------------------------------------------
// mscc_checker
// port-level checks on the circle classifier request and result timing
// ----------------------------------------------------------------------------
`include "marching_squares_circle_classifier_unit_assert.svh"

module mscc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_command,
   input logic rsp_strobe
);
   import mscc_pkg::*;

   logic classify_req;
   logic load_req;

   assign classify_req = start && !busy && (req_command == CMD_CLASSIFY);
   assign load_req     = start && !busy && (req_command == CMD_LOAD);

   // a classify request always occupies the unit
   `MSCC_ASSERT_NEXT(a_classify_busy, clock, reset, classify_req, busy)
   // a load request finishes at once
   `MSCC_ASSERT_NEXT(a_load_done, clock, reset, load_req, !busy && !rsp_strobe)
   // result shows once the unit is free again
   `MSCC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // the end of a classify always gives a result
   `MSCC_ASSERT_NOW(a_end_result, clock, reset, $fell(busy) && !$past(reset), rsp_strobe)
   // never two results back to back
   `MSCC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind marching_squares_circle_classifier_unit mscc_checker u_mscc_checker (.*);

### dv/mscc_case_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscc_case_checker
// Watches the request, result and register ports of the circle classifier.
// Keeps its own circle table and count, works out the marching-squares case
// of every accepted classify request and checks the results in order.
// ----------------------------------------------------------------------------
module mscc_case_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_command,
   input  logic [3:0]                      req_slot,
   input  logic [15:0]                     req_radius,
   input  logic [15:0]                     req_point0_x,
   input  logic [15:0]                     req_point0_y,
   input  logic [15:0]                     req_point1_x,
   input  logic [15:0]                     req_point1_y,
   input  logic [15:0]                     req_point2_x,
   input  logic [15:0]                     req_point2_y,
   input  logic [15:0]                     req_point3_x,
   input  logic [15:0]                     req_point3_y,
   input  logic                            rsp_strobe,
   input  logic [3:0]                      rsp_case_code,
   input  logic                            csr_write_enable,
   input  logic [mscc_pkg::COUNT_BITS-1:0] csr_write_data,
   output int unsigned                     fail_count,
   output int unsigned                     outstanding
);

   import mscc_pkg::*;

   circle_type            circles [MAX_CIRCLES];
   logic [COUNT_BITS-1:0] circle_count;
   logic [3:0]            case_queue [$];
   int unsigned           n_fail = 0;

   // corner k sets bit 3-k when it lies on or inside any counted circle
   function automatic logic [3:0] tile_case(input corner_set_type tile);
      logic [3:0]  code;
      int          n;
      logic [33:0] dx;
      logic [33:0] dy;
      logic [33:0] rr;
      code = '0;
      n = (circle_count > MAX_CIRCLES) ? MAX_CIRCLES : int'(circle_count);
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int i = 0; i < n; i++) begin
            dx = 34'((tile[k].x >= circles[i].cx) ? tile[k].x - circles[i].cx
                                                  : circles[i].cx - tile[k].x);
            dy = 34'((tile[k].y >= circles[i].cy) ? tile[k].y - circles[i].cy
                                                  : circles[i].cy - tile[k].y);
            rr = 34'(circles[i].r);
            rr = rr * rr;
            if (dx * dx + dy * dy <= rr) begin
               code[NUM_CORNERS-1-k] = 1'b1;
            end
         end
      end
      return code;
   endfunction

   always @(posedge clock) begin : watch
      corner_set_type tile;
      logic [3:0]     want;
      if (reset) begin
         circle_count = '0;
         case_queue.delete();
         for (int i = 0; i < MAX_CIRCLES; i++) begin
            circles[i] = '0;
         end
      end else begin
         if (csr_write_enable) begin
            circle_count = csr_write_data;
         end
         if (start && !busy) begin
            if (req_command == CMD_LOAD) begin
               circles[req_slot].cx = req_point0_x;
               circles[req_slot].cy = req_point0_y;
               circles[req_slot].r  = req_radius;
            end else begin
               tile[0].x = req_point0_x;
               tile[0].y = req_point0_y;
               tile[1].x = req_point1_x;
               tile[1].y = req_point1_y;
               tile[2].x = req_point2_x;
               tile[2].y = req_point2_y;
               tile[3].x = req_point3_x;
               tile[3].y = req_point3_y;
               case_queue = {case_queue, tile_case(tile)};
            end
         end
         if (rsp_strobe) begin
            if (case_queue.size() == 0) begin
               n_fail++;
               $error("case_code expected none actual %0d", rsp_case_code);
            end else begin
               want = case_queue.pop_front();
               if (rsp_case_code !== want) begin
                  n_fail++;
                  $error("case_code expected %0d actual %0d", want, rsp_case_code);
               end
            end
         end
      end
      fail_count  <= n_fail;
      outstanding <= case_queue.size();
   end

endmodule

### dv/tb_marching_squares_circle_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_marching_squares_circle_classifier_unit
// Drives load and classify requests into the circle classifier with random
// gaps, steps the circle count through its range between phases and leaves
// the checking to the checker beside the block. Directed tiles cover the
// boundary, zero radius, full-range circles and counts of zero and above
// the table; random corners land anywhere or at and around loaded circles.
// ----------------------------------------------------------------------------
module tb_marching_squares_circle_classifier_unit;

   import mscc_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int PHASES        = 10;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_command;
   logic [3:0]            req_slot;
   logic [15:0]           req_radius;
   logic [15:0]           req_point0_x;
   logic [15:0]           req_point0_y;
   logic [15:0]           req_point1_x;
   logic [15:0]           req_point1_y;
   logic [15:0]           req_point2_x;
   logic [15:0]           req_point2_y;
   logic [15:0]           req_point3_x;
   logic [15:0]           req_point3_y;
   logic                  rsp_strobe;
   logic [3:0]            rsp_case_code;
   logic                  csr_write_enable;
   logic [COUNT_BITS-1:0] csr_write_data;
   int unsigned           fail_count;
   int unsigned           outstanding;

   // circles as loaded, used only to aim corners
   coord_type   aim_cx [MAX_CIRCLES];
   coord_type   aim_cy [MAX_CIRCLES];
   coord_type   aim_r  [MAX_CIRCLES];
   int unsigned live_count = 0;
   bit          no_idle    = 1'b0;
   int unsigned idle_cycles = 0;

   marching_squares_circle_classifier_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_radius       (req_radius),
      .req_point0_x     (req_point0_x),
      .req_point0_y     (req_point0_y),
      .req_point1_x     (req_point1_x),
      .req_point1_y     (req_point1_y),
      .req_point2_x     (req_point2_x),
      .req_point2_y     (req_point2_y),
      .req_point3_x     (req_point3_x),
      .req_point3_y     (req_point3_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_case_code    (rsp_case_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   mscc_case_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_radius       (req_radius),
      .req_point0_x     (req_point0_x),
      .req_point0_y     (req_point0_y),
      .req_point1_x     (req_point1_x),
      .req_point1_y     (req_point1_y),
      .req_point2_x     (req_point2_x),
      .req_point2_y     (req_point2_y),
      .req_point3_x     (req_point3_x),
      .req_point3_y     (req_point3_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_case_code    (rsp_case_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) begin
         return '0;
      end else if (v > 65535) begin
         return '1;
      end
      return coord_type'(v);
   endfunction

   function automatic corner_set_type make_tile(input coord_type x0, input coord_type y0,
                                                input coord_type x1, input coord_type y1,
                                                input coord_type x2, input coord_type y2,
                                                input coord_type x3, input coord_type y3);
      corner_set_type tile;
      tile[0].x = x0;
      tile[0].y = y0;
      tile[1].x = x1;
      tile[1].y = y1;
      tile[2].x = x2;
      tile[2].y = y2;
      tile[3].x = x3;
      tile[3].y = y3;
      return tile;
   endfunction

   task automatic send_request(input logic cmd, input logic [3:0] slot,
                               input coord_type radius, input corner_set_type tile);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= cmd;
      req_slot     <= slot;
      req_radius   <= radius;
      req_point0_x <= tile[0].x;
      req_point0_y <= tile[0].y;
      req_point1_x <= tile[1].x;
      req_point1_y <= tile[1].y;
      req_point2_x <= tile[2].x;
      req_point2_y <= tile[2].y;
      req_point3_x <= tile[3].x;
      req_point3_y <= tile[3].y;
      do @(posedge clock); while (busy);
      if (cmd == CMD_LOAD) begin
         aim_cx[slot] = tile[0].x;
         aim_cy[slot] = tile[0].y;
         aim_r[slot]  = radius;
      end
   endtask

   task automatic load_circle(input logic [3:0] slot, input coord_type cx,
                              input coord_type cy, input coord_type radius);
      send_request(CMD_LOAD, slot, radius,
                   make_tile(cx, cy, coord_type'($urandom), coord_type'($urandom),
                             coord_type'($urandom), coord_type'($urandom),
                             coord_type'($urandom), coord_type'($urandom)));
   endtask

   task automatic load_random_circle(input logic [3:0] slot);
      coord_type radius;
      case ($urandom_range(0, 7))
         0:       radius = '0;
         1:       radius = coord_type'($urandom);
         2, 3:    radius = coord_type'($urandom_range(0, 4095));
         default: radius = coord_type'($urandom_range(1, 600));
      endcase
      load_circle(slot, coord_type'($urandom), coord_type'($urandom), radius);
   endtask

   task automatic classify_tile(input corner_set_type tile);
      send_request(CMD_CLASSIFY, 4'($urandom), coord_type'($urandom), tile);
   endtask

   // corners land anywhere, on a circle edge give or take one, or near a circle
   task automatic pick_corner(output coord_type x, output coord_type y);
      int unsigned s;
      int unsigned eff;
      int          cx;
      int          cy;
      int          r;
      int          span;
      int          nudge;
      eff = (live_count == 0 || live_count > MAX_CIRCLES) ? MAX_CIRCLES : live_count;
      s = $urandom_range(0, eff - 1);
      cx = int'(aim_cx[s]);
      cy = int'(aim_cy[s]);
      r = int'(aim_r[s]);
      nudge = int'($urandom_range(0, 2)) - 1;
      x = aim_cx[s];
      y = aim_cy[s];
      case ($urandom_range(0, 3))
         0: begin
            x = coord_type'($urandom);
            y = coord_type'($urandom);
         end
         1: begin
            case ($urandom_range(0, 3))
               0:       x = clamp_coord(cx + r + nudge);
               1:       x = clamp_coord(cx - r + nudge);
               2:       y = clamp_coord(cy + r + nudge);
               default: y = clamp_coord(cy - r + nudge);
            endcase
         end
         default: begin
            span = r + 2;
            x = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
            y = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
         end
      endcase
   endtask

   task automatic classify_random_tile();
      corner_set_type tile;
      coord_type      x;
      coord_type      y;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         pick_corner(x, y);
         tile[k].x = x;
         tile[k].y = y;
      end
      classify_tile(tile);
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_circle_count(input logic [COUNT_BITS-1:0] value);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      live_count = 32'(value);
   endtask

   initial begin : stimulus
      start            = 1'b0;
      reset            = 1'b1;
      req_command      = CMD_LOAD;
      req_slot         = '0;
      req_radius       = '0;
      req_point0_x     = '0;
      req_point0_y     = '0;
      req_point1_x     = '0;
      req_point1_y     = '0;
      req_point2_x     = '0;
      req_point2_y     = '0;
      req_point3_x     = '0;
      req_point3_y     = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      for (int i = 0; i < MAX_CIRCLES; i++) begin
         aim_cx[i] = '0;
         aim_cy[i] = '0;
         aim_r[i]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // count zero straight after reset
      classify_tile(make_tile(0, 0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 0));

      // fill the whole table so no request reads an empty entry
      load_circle(0, 1000, 1000, 50);
      load_circle(1, 0, 0, 16'hFFFF);
      load_circle(2, 16'hFFFF, 16'hFFFF, 0);
      load_circle(3, 30000, 200, 3);
      for (int i = 4; i < MAX_CIRCLES; i++) begin
         load_random_circle(4'(i));
      end

      // on the edge, one past it, and a diagonal point on it
      write_circle_count(1);
      classify_tile(make_tile(1050, 1000, 1051, 1000, 1030, 1040, 1000, 949));

      // zero radius hit, full-range circle edge and just beyond
      write_circle_count(3);
      classify_tile(make_tile(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 0, 16'hFFFF,
                              46341, 46340));

      write_circle_count(COUNT_BITS'(MAX_CIRCLES));
      classify_tile(make_tile(30003, 200, 30002, 202, 0, 0, 16'hFFFF, 0));

      // count above the table
      write_circle_count('1);
      classify_tile(make_tile(0, 0, 0, 0, 0, 0, 0, 0));
      classify_tile(make_tile('1, '1, '1, '1, '1, '1, '1, '1));

      write_circle_count(0);
      classify_tile(make_tile(1000, 1000, 0, 0, 16'hFFFF, 16'hFFFF, 30000, 200));

      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 5))
            0:       write_circle_count(0);
            1:       write_circle_count(1);
            2:       write_circle_count(COUNT_BITS'(MAX_CIRCLES));
            3:       write_circle_count(COUNT_BITS'($urandom_range(MAX_CIRCLES + 1, 31)));
            default: write_circle_count(COUNT_BITS'($urandom_range(2, MAX_CIRCLES - 1)));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               load_random_circle(4'($urandom_range(0, MAX_CIRCLES - 1)));
            end else begin
               classify_random_tile();
            end
         end
      end

      wait_quiet();
      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
